### hdl/ssbpd_pkg.sv
// shared types and constants for the strict second-buy pivot detector
package ssbpd_pkg;

  localparam int WinDepth = 5;
  localparam int PriceW   = 32;
  localparam int RatioW   = 16;
  localparam int AgeW     = 2;

  typedef logic [1:0]        pivot_kind_t;
  typedef logic [PriceW-1:0] price_t;
  typedef logic [RatioW-1:0] ratio_t;
  typedef logic [AgeW-1:0]   age_t;

  localparam pivot_kind_t PIVOT_NONE   = 2'd0;
  localparam pivot_kind_t PIVOT_TOP    = 2'd1;
  localparam pivot_kind_t PIVOT_BOTTOM = 2'd2;

  // register indexes on the config port
  localparam logic REG_NOT_BREAK  = 1'b0;
  localparam logic REG_DIVERGENCE = 1'b1;

  typedef struct packed {
    logic   arm;
    price_t level;
  } pattern_res_t;

endpackage

### hdl/strict_second_buy_pivot_detector.sv
// an accepted item passes the input register, then the result register, to its result
// throughput: one item per cycle unless out_stall_i holds back a finished result
// the result register lets the input register take an item while a result waits on out_stall_i
// reset: pivot history and pending slots empty, ratios at 63570 and 58982
// end of series: the bar is processed, then history and pending slots are cleared
module strict_second_buy_pivot_detector #(
  parameter int CONFIRM_BARS = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  pivot_kind_i,
  input  logic [31:0] bar_high_i,
  input  logic [31:0] bar_low_i,
  input  logic [31:0] bar_close_i,
  input  logic        end_of_series_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        older_hit_o,
  output logic [1:0]  older_back_o,
  output logic        newer_hit_o,
  output logic [1:0]  newer_back_o
);

  localparam int Depth = ssbpd_pkg::WinDepth;
  localparam ssbpd_pkg::age_t ConfirmAge = ssbpd_pkg::age_t'(CONFIRM_BARS);

  // config registers
  ssbpd_pkg::ratio_t not_break_q, divergence_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      not_break_q  <= 16'd63570;
      divergence_q <= 16'd58982;
    end else if (cfg_wr) begin
      case (paddr[2])
        ssbpd_pkg::REG_NOT_BREAK:  not_break_q  <= pwdata[15:0];
        ssbpd_pkg::REG_DIVERGENCE: divergence_q <= pwdata[15:0];
        default:                   not_break_q  <= not_break_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      ssbpd_pkg::REG_NOT_BREAK:  prdata = {16'h0000, not_break_q};
      ssbpd_pkg::REG_DIVERGENCE: prdata = {16'h0000, divergence_q};
      default:                   prdata = '0;
    endcase
  end

  // input register
  logic                   s1_valid_q;
  ssbpd_pkg::pivot_kind_t s1_kind_q;
  ssbpd_pkg::price_t      s1_high_q, s1_low_q, s1_close_q;
  logic                   s1_eos_q;
  logic                   out_free, proc, in_acc;

  assign out_free   = !out_valid_o || !out_stall_i;
  assign proc       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (proc) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_kind_q  <= pivot_kind_i;
      s1_high_q  <= bar_high_i;
      s1_low_q   <= bar_low_i;
      s1_close_q <= bar_close_i;
      s1_eos_q   <= end_of_series_i;
    end
  end

  // series state
  ssbpd_pkg::pivot_kind_t kind_q [Depth];
  ssbpd_pkg::price_t      price_q [Depth];
  logic                   pv_q [2];
  ssbpd_pkg::age_t        pa_q [2];
  ssbpd_pkg::price_t      pl_q [2];

  ssbpd_pkg::pivot_kind_t kind_d [Depth];
  ssbpd_pkg::price_t      price_d [Depth];
  logic                   pv_d [2];
  ssbpd_pkg::age_t        pa_d [2];
  ssbpd_pkg::price_t      pl_d [2];
  logic                   hit_d [2];
  ssbpd_pkg::age_t        back_d [2];
  logic                   shift_in;
  ssbpd_pkg::pattern_res_t pat;

  assign shift_in = (s1_kind_q == ssbpd_pkg::PIVOT_TOP) ||
                    (s1_kind_q == ssbpd_pkg::PIVOT_BOTTOM);

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      kind_d[i]  = kind_q[i];
      price_d[i] = price_q[i];
    end
    if (shift_in) begin
      for (int i = 0; i < Depth - 1; i++) begin
        kind_d[i]  = kind_q[i+1];
        price_d[i] = price_q[i+1];
      end
      kind_d[Depth-1]  = s1_kind_q;
      price_d[Depth-1] = (s1_kind_q == ssbpd_pkg::PIVOT_TOP) ? s1_high_q : s1_low_q;
    end
  end

  ssbpd_pattern u_pattern (
    .kinds_i      (kind_d),
    .prices_i     (price_d),
    .not_break_i  (not_break_q),
    .divergence_i (divergence_q),
    .res_o        (pat)
  );

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      pv_d[i] = pv_q[i];
      pa_d[i] = pa_q[i];
      pl_d[i] = pl_q[i];
    end
    // arm, dropping the older slot when both are busy
    if ((s1_kind_q == ssbpd_pkg::PIVOT_BOTTOM) && pat.arm) begin
      if (pv_d[1]) begin
        pv_d[0] = 1'b1;
        pa_d[0] = pa_d[1];
        pl_d[0] = pl_d[1];
        pv_d[1] = 1'b0;
      end
      if (pv_d[0]) begin
        pv_d[1] = 1'b1;
        pa_d[1] = '0;
        pl_d[1] = pat.level;
      end else begin
        pv_d[0] = 1'b1;
        pa_d[0] = '0;
        pl_d[0] = pat.level;
      end
    end
    // confirmation by this close
    for (int i = 0; i < 2; i++) begin
      hit_d[i]  = pv_d[i] && (s1_close_q > pl_d[i]);
      back_d[i] = hit_d[i] ? pa_d[i] : '0;
      if (hit_d[i]) begin
        pv_d[i] = 1'b0;
      end
    end
    // aging and expiry
    for (int i = 0; i < 2; i++) begin
      if (pv_d[i]) begin
        if (pa_d[i] >= ConfirmAge) begin
          pv_d[i] = 1'b0;
        end else begin
          pa_d[i] = pa_d[i] + 2'd1;
        end
      end
    end
    // a lone slot lives in slot 0
    if (!pv_d[0] && pv_d[1]) begin
      pv_d[0] = 1'b1;
      pa_d[0] = pa_d[1];
      pl_d[0] = pl_d[1];
      pv_d[1] = 1'b0;
    end
    if (s1_eos_q) begin
      pv_d[0] = 1'b0;
      pv_d[1] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        kind_q[i] <= ssbpd_pkg::PIVOT_NONE;
      end
      pv_q[0] <= 1'b0;
      pv_q[1] <= 1'b0;
    end else if (proc) begin
      if (s1_eos_q) begin
        for (int i = 0; i < Depth; i++) begin
          kind_q[i] <= ssbpd_pkg::PIVOT_NONE;
        end
      end else begin
        kind_q <= kind_d;
      end
      pv_q <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      price_q <= price_d;
      pa_q    <= pa_d;
      pl_q    <= pl_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (proc) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      older_hit_o  <= hit_d[0];
      older_back_o <= back_d[0];
      newer_hit_o  <= hit_d[1];
      newer_back_o <= back_d[1];
    end
  end

  a_lone_slot_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q[1] |-> pv_q[0])
    else $error("newer slot busy while older slot empty");

  a_back_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (!older_hit_o || !newer_hit_o) |->
      (older_hit_o || older_back_o == 2'd0) && (newer_hit_o || newer_back_o == 2'd0))
    else $error("back field set without a hit");

  a_stall_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_o)
    else $error("input stalled with room in the pipeline");

  a_eos_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && s1_eos_q |=> !pv_q[0] && !pv_q[1] && kind_q[Depth-1] == ssbpd_pkg::PIVOT_NONE)
    else $error("series state kept after end of series");

  a_result_follows_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |=> out_valid_o)
    else $error("processed item produced no result");

endmodule

### hdl/ssbpd_pattern.sv
// bottom-top-bottom-top-bottom pattern check over the pivot window
module ssbpd_pattern (
  input  ssbpd_pkg::pivot_kind_t  kinds_i [ssbpd_pkg::WinDepth],
  input  ssbpd_pkg::price_t       prices_i [ssbpd_pkg::WinDepth],
  input  ssbpd_pkg::ratio_t       not_break_i,
  input  ssbpd_pkg::ratio_t       divergence_i,
  output ssbpd_pkg::pattern_res_t res_o
);

  ssbpd_pkg::price_t   b1, t1, b2, t2, b3;
  ssbpd_pkg::price_t   range_hi, range_lo;
  logic                shape_ok;
  logic                overlap_ok, not_break_ok, below_ok, diverge_ok;
  logic [47:0]         b3_scaled;
  logic [47:0]         b1_scaled;
  logic signed [32:0]  drop1, drop2;
  logic signed [48:0]  drop2_scaled;
  logic signed [49:0]  drop1_scaled;

  assign b1 = prices_i[0];
  assign t1 = prices_i[1];
  assign b2 = prices_i[2];
  assign t2 = prices_i[3];
  assign b3 = prices_i[4];

  assign shape_ok = (kinds_i[0] == ssbpd_pkg::PIVOT_BOTTOM) &&
                    (kinds_i[1] == ssbpd_pkg::PIVOT_TOP) &&
                    (kinds_i[2] == ssbpd_pkg::PIVOT_BOTTOM) &&
                    (kinds_i[3] == ssbpd_pkg::PIVOT_TOP) &&
                    (kinds_i[4] == ssbpd_pkg::PIVOT_BOTTOM);

  assign range_hi = (t1 < t2) ? t1 : t2;
  assign range_lo = (b1 > b2) ? b1 : b2;

  assign overlap_ok = range_hi > range_lo;

  assign b3_scaled    = {b3, 16'h0000};
  assign b1_scaled    = 48'(b1) * 48'(not_break_i);
  assign not_break_ok = b3_scaled >= b1_scaled;

  assign below_ok = b3 < range_lo;

  // drops may go negative, so compare in signed arithmetic
  assign drop1        = $signed({1'b0, t1}) - $signed({1'b0, b2});
  assign drop2        = $signed({1'b0, t2}) - $signed({1'b0, b3});
  assign drop2_scaled = $signed({drop2, 16'h0000});
  assign drop1_scaled = drop1 * $signed({1'b0, divergence_i});
  assign diverge_ok   = drop2_scaled < drop1_scaled;

  assign res_o.arm   = shape_ok && overlap_ok && not_break_ok && below_ok && diverge_ok;
  assign res_o.level = range_lo;

endmodule
